### sv/geometry_aware_upsample_pixel_macros.svh
// assertion macros used by the checker file
`ifndef GEOMETRY_AWARE_UPSAMPLE_PIXEL_MACROS_SVH
`define GEOMETRY_AWARE_UPSAMPLE_PIXEL_MACROS_SVH

// same-cycle implication, sampled on the rising clock, off during reset
`define GAUP_ASSERT_NOW(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, sampled on the rising clock, off during reset
`define GAUP_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error(msg);

`endif

### sv/gaup_pkg.sv
package gaup_pkg;

  localparam int NUM_CH    = 4;
  localparam int NUM_NB    = 4;
  localparam int SUB_W     = 4;
  localparam int COLOR_W   = 64;
  localparam int ID_W      = 32;
  localparam int RATIO_W   = 5;
  localparam logic [RATIO_W-1:0] RATIO_RESET = 5'd2;

  // input request layout, lowest bit first
  localparam int SUB_X_LSB     = 0;
  localparam int SUB_Y_LSB     = 4;
  localparam int COLOR_LSB     = 8;    // upper left, lower left, lower right, upper right
  localparam int ID_LSB        = 264;  // same neighbor order
  localparam int ID_CENTER_LSB = 392;
  localparam int DIRECT_LSB    = 424;
  localparam int S_TDATA_W     = 488;

  localparam int M_TDATA_W = 64;
  localparam int M_TUSER_W = 1;

endpackage

### sv/gaup_div.sv
module gaup_div #(
  parameter int NUM_W  = 44,
  parameter int DEN_W  = 26,
  parameter int QUOT_W = 16
) (
  input  logic              clk_i,
  input  logic              en_i,
  input  logic [NUM_W-1:0]  num_i,
  input  logic [DEN_W-1:0]  den_i,
  output logic [QUOT_W-1:0] quot_o
);

  localparam int REM_W = DEN_W + 1;

  logic [DEN_W-1:0]  rem_q  [QUOT_W];
  logic [QUOT_W-1:0] low_q  [QUOT_W];
  logic [DEN_W-1:0]  den_q  [QUOT_W];
  logic [QUOT_W-1:0] quot_q [QUOT_W];

  for (genvar k = 0; k < QUOT_W; k++) begin : g_step
    logic [DEN_W-1:0]  rem_in;
    logic [QUOT_W-1:0] low_in;
    logic [DEN_W-1:0]  den_in;
    logic [QUOT_W-1:0] quot_in;
    logic [REM_W-1:0]  trial;
    logic              ge;
    logic [DEN_W-1:0]  rem_d;

    if (k == 0) begin : g_first
      // quotient fits QUOT_W bits, so the top part is already below the divisor
      assign rem_in  = DEN_W'(num_i >> QUOT_W);
      assign low_in  = num_i[QUOT_W-1:0];
      assign den_in  = den_i;
      assign quot_in = '0;
    end else begin : g_rest
      assign rem_in  = rem_q[k-1];
      assign low_in  = low_q[k-1];
      assign den_in  = den_q[k-1];
      assign quot_in = quot_q[k-1];
    end

    always_comb begin
      trial = {rem_in, low_in[QUOT_W-1]};
      ge    = (trial >= {1'b0, den_in});
      rem_d = ge ? DEN_W'(trial - {1'b0, den_in}) : DEN_W'(trial);
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[k]  <= rem_d;
        low_q[k]  <= low_in << 1;
        den_q[k]  <= den_in;
        quot_q[k] <= {quot_in[QUOT_W-2:0], ge};
      end
    end
  end

  assign quot_o = quot_q[QUOT_W-1];

endmodule

### sv/geometry_aware_upsample_pixel.sv
// channel   | dir | handshake                     | payload
// s_axis    | in  | s_axis_tvalid / s_axis_tready | s_axis_tdata: one pixel request
// m_axis    | out | m_axis_tvalid / m_axis_tready | m_axis_tdata, m_axis_tuser
// cfg       | in  | cfg_valid_i / cfg_ready_o     | cfg_data_i: upscale ratio
//
// one request per cycle while m_axis is not stalled; the restoring divider
// takes one quotient bit per stage
// rst_ni clears the valid bits and sets the ratio to 2; no clearing pass
// a stall on m_axis freezes every stage at once and drops s_axis_tready
// cfg_ready_o is always high; write the ratio only while the pipe is empty
module geometry_aware_upsample_pixel #(
  parameter int MAX_RATIO    = 16,
  parameter int CHANNEL_BITS = 16,
  parameter int FRAC_BITS    = 8
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   s_axis_tvalid,
  output logic                                   s_axis_tready,
  // sub_x, sub_y, color_upper_left, color_lower_left, color_lower_right,
  // color_upper_right, id_upper_left, id_lower_left, id_lower_right,
  // id_upper_right, id_center, direct_color
  input  logic [gaup_pkg::S_TDATA_W-1:0]         s_axis_tdata,
  output logic                                   m_axis_tvalid,
  input  logic                                   m_axis_tready,
  // out_color
  output logic [gaup_pkg::M_TDATA_W-1:0]         m_axis_tdata,
  // fallback_used
  output logic [gaup_pkg::M_TUSER_W-1:0]         m_axis_tuser,
  input  logic                                   cfg_valid_i,
  output logic                                   cfg_ready_o,
  input  logic [gaup_pkg::RATIO_W-1:0]           cfg_data_i
);

  localparam int NCH = gaup_pkg::NUM_CH;
  localparam int NNB = gaup_pkg::NUM_NB;
  localparam int CB  = CHANNEL_BITS;
  localparam int CW  = NCH * CB;                                  // used color bits
  localparam int RW  = $clog2(MAX_RATIO + 1);                     // ratio
  localparam int DW  = $clog2(MAX_RATIO * (2 ** FRAC_BITS) + 1);  // D, U, V
  localparam int WW  = 2 * DW;                                    // weights and their sum
  localparam int PW  = WW + CB;                                   // weight times channel
  localparam int NW  = WW + CB + 2;                               // rounded numerator
  localparam int AW  = CB + 2;                                    // four-way channel sum

  // whole pipe moves together whenever the output register can take a result
  logic en;
  logic out_vld_q;
  assign en            = !out_vld_q || m_axis_tready;
  assign s_axis_tready = en;

  // ratio register
  logic [gaup_pkg::RATIO_W-1:0] ratio_q;
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ratio_q <= gaup_pkg::RATIO_RESET;
    end else if (cfg_valid_i) begin
      ratio_q <= cfg_data_i;
    end
  end

  // ratio clamped to 1..MAX_RATIO
  logic [RW-1:0] r_eff;
  always_comb begin
    if (ratio_q == '0) begin
      r_eff = RW'(1);
    end else if (int'(ratio_q) > MAX_RATIO) begin
      r_eff = RW'(MAX_RATIO);
    end else begin
      r_eff = RW'(ratio_q);
    end
  end

  // offset clamped below the ratio, scaled, zero replaced by one step
  function automatic logic [DW-1:0] off_units(input logic [gaup_pkg::SUB_W-1:0] sub,
                                               input logic [RW-1:0] r);
    logic [DW-1:0] s;
    if (int'(sub) > int'(r) - 1) begin
      s = DW'(r - RW'(1));
    end else begin
      s = DW'(sub);
    end
    s = s << FRAC_BITS;
    if (s == '0) begin
      s = DW'(1);
    end
    return s;
  endfunction

  // request unpacking
  logic [gaup_pkg::SUB_W-1:0] in_sub_x, in_sub_y;
  logic [NNB-1:0][CW-1:0]     in_col;
  logic [NNB-1:0]             in_match;
  logic [gaup_pkg::ID_W-1:0]  in_id_center;
  logic [CW-1:0]              in_dir;
  logic [DW-1:0]              in_d, in_u, in_v;

  always_comb begin
    in_sub_x     = s_axis_tdata[gaup_pkg::SUB_X_LSB +: gaup_pkg::SUB_W];
    in_sub_y     = s_axis_tdata[gaup_pkg::SUB_Y_LSB +: gaup_pkg::SUB_W];
    in_id_center = s_axis_tdata[gaup_pkg::ID_CENTER_LSB +: gaup_pkg::ID_W];
    in_dir       = s_axis_tdata[gaup_pkg::DIRECT_LSB +: CW];
    for (int i = 0; i < NNB; i++) begin
      in_col[i]   = s_axis_tdata[gaup_pkg::COLOR_LSB + i * gaup_pkg::COLOR_W +: CW];
      in_match[i] = (s_axis_tdata[gaup_pkg::ID_LSB + i * gaup_pkg::ID_W +: gaup_pkg::ID_W]
                     == in_id_center);
    end
    in_d = DW'(r_eff) << FRAC_BITS;
    in_u = off_units(in_sub_x, r_eff);
    in_v = off_units(in_sub_y, r_eff);
  end

  // stage a: offsets and their complements, id matches
  logic                   a_vld_q, a_fb_q;
  logic [DW-1:0]          a_u_q, a_v_q, a_du_q, a_dv_q;
  logic [NNB-1:0]         a_match_q;
  logic [NNB-1:0][CW-1:0] a_col_q;
  logic [CW-1:0]          a_dir_q;

  // stage b: masked bilinear weights
  logic                   b_vld_q, b_fb_q;
  logic [NNB-1:0][WW-1:0] b_w_q;
  logic [NNB-1:0][CW-1:0] b_col_q;
  logic [CW-1:0]          b_dir_q;

  // stage c: weighted channels, weight sum, plain channel sums
  logic                            c_vld_q, c_fb_q;
  logic [NCH-1:0][NNB-1:0][PW-1:0] c_prod_q;
  logic [WW-1:0]                   c_wsum_q;
  logic [NCH-1:0][AW-1:0]          c_asum_q;
  logic [CW-1:0]                   c_dir_q;

  // stage d: rounded numerators and averages
  logic                   d_vld_q, d_fb_q;
  logic [NCH-1:0][NW-1:0] d_num_q;
  logic [WW-1:0]          d_wsum_q;
  logic [NCH-1:0][CB-1:0] d_avg_q;
  logic [CW-1:0]          d_dir_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_vld_q <= 1'b0;
      b_vld_q <= 1'b0;
      c_vld_q <= 1'b0;
      d_vld_q <= 1'b0;
    end else if (en) begin
      a_vld_q <= s_axis_tvalid;
      b_vld_q <= a_vld_q;
      c_vld_q <= b_vld_q;
      d_vld_q <= c_vld_q;
    end
  end

  logic [NNB-1:0][WW-1:0] b_w_d;
  logic [NCH-1:0][NNB-1:0][PW-1:0] c_prod_d;
  logic [WW+1:0]          c_wsum_full;
  logic [NCH-1:0][AW-1:0] c_asum_d;
  logic [NCH-1:0][NW-1:0] d_num_d;
  logic [NCH-1:0][CB-1:0] d_avg_d;
  logic [AW-1:0]          avg_tmp;

  always_comb begin
    // neighbor order: upper left, lower left, lower right, upper right
    b_w_d[0] = WW'(a_du_q) * WW'(a_v_q);
    b_w_d[1] = WW'(a_du_q) * WW'(a_dv_q);
    b_w_d[2] = WW'(a_u_q) * WW'(a_dv_q);
    b_w_d[3] = WW'(a_u_q) * WW'(a_v_q);
    for (int i = 0; i < NNB; i++) begin
      if (!a_match_q[i]) begin
        b_w_d[i] = '0;
      end
    end

    c_wsum_full = (WW+2)'(b_w_q[0]) + (WW+2)'(b_w_q[1])
                + (WW+2)'(b_w_q[2]) + (WW+2)'(b_w_q[3]);
    for (int c = 0; c < NCH; c++) begin
      c_asum_d[c] = '0;
      for (int i = 0; i < NNB; i++) begin
        c_prod_d[c][i] = PW'(b_w_q[i]) * PW'(b_col_q[i][c*CB +: CB]);
        c_asum_d[c]    = c_asum_d[c] + AW'(b_col_q[i][c*CB +: CB]);
      end
    end

    for (int c = 0; c < NCH; c++) begin
      d_num_d[c] = NW'(c_prod_q[c][0]) + NW'(c_prod_q[c][1])
                 + NW'(c_prod_q[c][2]) + NW'(c_prod_q[c][3])
                 + NW'(c_wsum_q >> 1);
      avg_tmp    = c_asum_q[c] + AW'(2);
      d_avg_d[c] = avg_tmp[AW-1:2];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      a_u_q     <= in_u;
      a_v_q     <= in_v;
      a_du_q    <= in_d - in_u;
      a_dv_q    <= in_d - in_v;
      a_match_q <= in_match;
      a_fb_q    <= ~|in_match;
      a_col_q   <= in_col;
      a_dir_q   <= in_dir;

      b_w_q   <= b_w_d;
      b_fb_q  <= a_fb_q;
      b_col_q <= a_col_q;
      b_dir_q <= a_dir_q;

      c_prod_q <= c_prod_d;
      c_wsum_q <= WW'(c_wsum_full);
      c_asum_q <= c_asum_d;
      c_fb_q   <= b_fb_q;
      c_dir_q  <= b_dir_q;

      d_num_q  <= d_num_d;
      d_wsum_q <= c_wsum_q;
      d_avg_q  <= d_avg_d;
      d_fb_q   <= c_fb_q;
      d_dir_q  <= c_dir_q;
    end
  end

  // per-channel dividers, one quotient bit per stage
  logic [NCH-1:0][CB-1:0] quot;

  for (genvar c = 0; c < NCH; c++) begin : g_div
    gaup_div #(
      .NUM_W  (NW),
      .DEN_W  (WW),
      .QUOT_W (CB)
    ) u_div (
      .clk_i  (clk_i),
      .en_i   (en),
      .num_i  (d_num_q[c]),
      .den_i  (d_wsum_q),
      .quot_o (quot[c])
    );
  end

  // side line alongside the dividers
  typedef struct packed {
    logic                   fb;
    logic [NCH-1:0][CB-1:0] avg;
    logic [CW-1:0]          dir;
  } side_t;

  logic  side_vld_q [CB];
  side_t side_q     [CB];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < CB; k++) begin
        side_vld_q[k] <= 1'b0;
      end
    end else if (en) begin
      side_vld_q[0] <= d_vld_q;
      for (int k = 1; k < CB; k++) begin
        side_vld_q[k] <= side_vld_q[k-1];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      side_q[0] <= '{fb: d_fb_q, avg: d_avg_q, dir: d_dir_q};
      for (int k = 1; k < CB; k++) begin
        side_q[k] <= side_q[k-1];
      end
    end
  end

  // direct plus indirect, saturated per channel
  side_t                     last;
  logic [CB-1:0]             ind;
  logic [CB:0]               csum;
  logic [gaup_pkg::M_TDATA_W-1:0] out_data_d;

  always_comb begin
    last       = side_q[CB-1];
    out_data_d = '0;
    for (int c = 0; c < NCH; c++) begin
      ind  = last.fb ? last.avg[c] : quot[c];
      csum = {1'b0, last.dir[c*CB +: CB]} + {1'b0, ind};
      out_data_d[c*CB +: CB] = csum[CB] ? {CB{1'b1}} : csum[CB-1:0];
    end
  end

  logic [gaup_pkg::M_TDATA_W-1:0] out_data_q;
  logic                           out_fb_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (en) begin
      out_vld_q <= side_vld_q[CB-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      out_data_q <= out_data_d;
      out_fb_q   <= last.fb;
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tuser  = gaup_pkg::M_TUSER_W'(out_fb_q);

endmodule

### sv/gaup_checker.sv
`include "geometry_aware_upsample_pixel_macros.svh"

module gaup_checker (
  input logic                            clk_i,
  input logic                            rst_ni,
  input logic                            s_axis_tready,
  input logic                            m_axis_tvalid,
  input logic                            m_axis_tready,
  input logic [gaup_pkg::M_TDATA_W-1:0]  m_axis_tdata,
  input logic [gaup_pkg::M_TUSER_W-1:0]  m_axis_tuser,
  input logic                            cfg_valid_i,
  input logic                            cfg_ready_o
);

  `GAUP_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, m_axis_tvalid && !m_axis_tready, m_axis_tvalid, "result dropped while stalled")
  `GAUP_ASSERT_NEXT(a_out_stable, clk_i, rst_ni, m_axis_tvalid && !m_axis_tready, $stable(m_axis_tdata) && $stable(m_axis_tuser), "result changed while stalled")
  `GAUP_ASSERT_NOW(a_stall_backs_up, clk_i, rst_ni, m_axis_tvalid && !m_axis_tready, !s_axis_tready, "input taken while output stalled")
  `GAUP_ASSERT_NOW(a_empty_takes, clk_i, rst_ni, !m_axis_tvalid, s_axis_tready, "input refused with empty output")
  `GAUP_ASSERT_NOW(a_cfg_ready, clk_i, rst_ni, cfg_valid_i, cfg_ready_o, "ratio write refused")

endmodule

bind geometry_aware_upsample_pixel gaup_checker u_gaup_checker (.*);
